// File: hdl/dphs_pkg.sv
// shared types and constants for the deque palindrome and half-sum unit
`timescale 1ns / 1ps
`default_nettype none

package dphs_pkg;

    // ring depth, a power of two so ring positions wrap by truncation
    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    // difference of the half sums: DEPTH/2 terms of WORD_W+1 bits each
    localparam int ACC_W   = WORD_W + 1 + IDX_W;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REPORT     = 3'd4
    } dphs_op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } dphs_status_t;

    typedef struct packed {
        logic apply;
        logic walk;
        logic load;
    } dphs_cmd_t;

    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } dphs_sts_t;

endpackage

`default_nettype wire

// File: hdl/deque_palindrome_halfsum_unit.sv
// top level of the deque palindrome and half-sum unit
// Usage: a bounded double-ended queue of 16 signed 32-bit words held in a ring.
// Input channel (s_valid/s_ready, s_op, s_value) takes one operation per
// transfer: push front, push back, pop front, pop back or report only.
// Output channel (m_valid/m_ready) returns one result per input transfer:
// entry count, palindrome flag, half-sum equality flag and status
// (done, push dropped when full, pop ignored when empty).
// Timing: after the input transfer the controller walks the n/2 entry pairs
// from both ends, one pair read per cycle from the two-port ring storage.
// The result is loaded into the output register once the walk is done and
// the register is free; a new input is taken in the cycle after the result
// is loaded, so an operation is not taken before the previous one has been
// walked and loaded.
// The result sits in an output register, so the next input is accepted while
// an earlier result still waits; if the receiver stalls longer, the walk
// finishes and holds until the output register frees up.
// Reset (aresetn low, synchronous): queue empty, front position zero, no
// result pending; ring contents are not cleared; unwritten slots are never used.
`timescale 1ns / 1ps
`default_nettype none

module deque_palindrome_halfsum_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [dphs_pkg::OP_W-1:0]          s_op,
    input  wire logic signed [dphs_pkg::WORD_W-1:0] s_value,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [dphs_pkg::CNT_W-1:0]              m_entry_count,
    output logic                                    m_is_palindrome,
    output logic                                    m_halves_equal,
    output logic [dphs_pkg::STAT_W-1:0]             m_status
);

    dphs_pkg::dphs_cmd_t cmd;
    dphs_pkg::dphs_sts_t sts;

    dphs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dphs_dpath u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_count   (m_entry_count),
        .m_is_palindrome (m_is_palindrome),
        .m_halves_equal  (m_halves_equal),
        .m_status        (m_status)
    );

endmodule

`default_nettype wire

// File: hdl/dphs_ctrl.sv
// controller state machine for the deque palindrome and half-sum unit
`timescale 1ns / 1ps
`default_nettype none

module dphs_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire dphs_pkg::dphs_sts_t    sts,
    output dphs_pkg::dphs_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready   = 1'b1;
                cmd.apply = s_valid;
                if (s_valid) begin
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_done) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (!sts.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/dphs_dpath.sv
// ring storage, pointers, pair walk and result register
`timescale 1ns / 1ps
`default_nettype none

module dphs_dpath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire dphs_pkg::dphs_cmd_t           cmd,
    output dphs_pkg::dphs_sts_t                sts,
    input  wire logic [dphs_pkg::OP_W-1:0]     s_op,
    input  wire logic signed [dphs_pkg::WORD_W-1:0] s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [dphs_pkg::CNT_W-1:0]         m_entry_count,
    output logic                               m_is_palindrome,
    output logic                               m_halves_equal,
    output logic [dphs_pkg::STAT_W-1:0]        m_status
);

    localparam int IDX_W  = dphs_pkg::IDX_W;
    localparam int CNT_W  = dphs_pkg::CNT_W;
    localparam int WORD_W = dphs_pkg::WORD_W;
    localparam int ACC_W  = dphs_pkg::ACC_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dphs_pkg::DEPTH);

    logic [WORD_W-1:0] mem [dphs_pkg::DEPTH];

    logic [IDX_W-1:0]  front_reg, front_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [dphs_pkg::STAT_W-1:0] stat_reg, stat_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              rd_valid_reg;
    logic [WORD_W-1:0] rd_lo_reg, rd_hi_reg;
    logic              pal_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [IDX_W-1:0]  pairs;
    logic              issue;
    logic [IDX_W-1:0]  addr_lo, addr_hi;
    logic              full, empty;

    logic              out_valid_reg;
    logic [CNT_W-1:0]  out_count_reg;
    logic              out_pal_reg;
    logic              out_heq_reg;
    logic [dphs_pkg::STAT_W-1:0] out_stat_reg;

    assign full  = (occ_reg == DEPTH_C);
    assign empty = (occ_reg == '0);

    // operation decode
    always_comb begin
        front_next = front_reg;
        occ_next   = occ_reg;
        stat_next  = dphs_pkg::ST_DONE;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        case (s_op)
            dphs_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    stat_next = dphs_pkg::ST_FULL;
                end else begin
                    front_next = front_reg - 1'b1;
                    occ_next   = occ_reg + 1'b1;
                    wr_en      = cmd.apply;
                    wr_addr    = front_reg - 1'b1;
                end
            end
            dphs_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    stat_next = dphs_pkg::ST_FULL;
                end else begin
                    occ_next = occ_reg + 1'b1;
                    wr_en    = cmd.apply;
                    wr_addr  = front_reg + occ_reg[IDX_W-1:0];
                end
            end
            dphs_pkg::OP_POP_FRONT: begin
                if (empty) begin
                    stat_next = dphs_pkg::ST_EMPTY;
                end else begin
                    front_next = front_reg + 1'b1;
                    occ_next   = occ_reg - 1'b1;
                end
            end
            dphs_pkg::OP_POP_BACK: begin
                if (empty) begin
                    stat_next = dphs_pkg::ST_EMPTY;
                end else begin
                    occ_next = occ_reg - 1'b1;
                end
            end
            default: begin
                stat_next = dphs_pkg::ST_DONE;
            end
        endcase
    end

    // pair walk from both ends
    assign pairs   = occ_reg[CNT_W-1:1];
    assign issue   = cmd.walk && (idx_reg != pairs);
    assign addr_lo = front_reg + idx_reg;
    assign addr_hi = front_reg + occ_reg[IDX_W-1:0] - 1'b1 - idx_reg;

    assign sts.walk_done = (idx_reg == pairs) && !rd_valid_reg;
    assign sts.out_busy  = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_value;
        end
        rd_lo_reg <= mem[addr_lo];
        rd_hi_reg <= mem[addr_hi];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg    <= '0;
            occ_reg      <= '0;
            stat_reg     <= dphs_pkg::ST_DONE;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            pal_reg      <= 1'b1;
            acc_reg      <= '0;
        end else begin
            if (cmd.apply) begin
                front_reg    <= front_next;
                occ_reg      <= occ_next;
                stat_reg     <= stat_next;
                idx_reg      <= '0;
                rd_valid_reg <= 1'b0;
                pal_reg      <= 1'b1;
                acc_reg      <= '0;
            end else begin
                rd_valid_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rd_valid_reg) begin
                    if (rd_lo_reg != rd_hi_reg) begin
                        pal_reg <= 1'b0;
                    end
                    acc_reg <= acc_reg
                             + ACC_W'($signed(rd_lo_reg))
                             - ACC_W'($signed(rd_hi_reg));
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            out_count_reg <= occ_reg;
            out_pal_reg   <= pal_reg;
            out_heq_reg   <= (acc_reg == '0);
            out_stat_reg  <= stat_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_entry_count   = out_count_reg;
    assign m_is_palindrome = out_pal_reg;
    assign m_halves_equal  = out_heq_reg;
    assign m_status        = out_stat_reg;

endmodule

`default_nettype wire

// File: bench/tb_deque_palindrome_halfsum_unit.sv
// self-checking testbench for the deque palindrome and half-sum unit
`timescale 1ns / 1ps

module tb_deque_palindrome_halfsum_unit;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int IDLE_PERCENT   = 19;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PAUSE_EVERY    = 300;

    localparam int OP_W   = dphs_pkg::OP_W;
    localparam int WORD_W = dphs_pkg::WORD_W;
    localparam int CNT_W  = dphs_pkg::CNT_W;
    localparam int STAT_W = dphs_pkg::STAT_W;
    localparam int DEPTH  = dphs_pkg::DEPTH;

    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_NEG = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CNT_W-1:0]       count;
        logic                   palindrome;
        logic                   halves;
        dphs_pkg::dphs_status_t status;
    } deque_report_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op = dphs_pkg::OP_REPORT;
    logic signed [WORD_W-1:0] s_value = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [CNT_W-1:0]         m_entry_count;
    logic                     m_is_palindrome;
    logic                     m_halves_equal;
    logic [STAT_W-1:0]        m_status;

    logic [WORD_W-1:0] held_words[$];
    deque_report_t     pending_reports[$];
    deque_report_t     oldest_report;
    int unsigned       mismatch_count = 0;
    int unsigned       sent_items = 0;
    int unsigned       quiet_cycles = 0;
    bit                calm = 1'b0;

    deque_palindrome_halfsum_unit DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_entry_count   (m_entry_count),
        .m_is_palindrome (m_is_palindrome),
        .m_halves_equal  (m_halves_equal),
        .m_status        (m_status)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // applies one operation to the shadow deque and returns the report it yields
    function automatic deque_report_t deque_apply(input logic [OP_W-1:0] op,
                                                  input logic [WORD_W-1:0] word);
        deque_report_t rep;
        longint        front_sum;
        longint        back_sum;
        int            n;
        rep.status = dphs_pkg::ST_DONE;
        case (op)
            dphs_pkg::OP_PUSH_FRONT, dphs_pkg::OP_PUSH_BACK: begin
                if (held_words.size() >= DEPTH) begin
                    rep.status = dphs_pkg::ST_FULL;
                end else if (op == dphs_pkg::OP_PUSH_FRONT) begin
                    held_words.push_front(word);
                end else begin
                    held_words.push_back(word);
                end
            end
            dphs_pkg::OP_POP_FRONT, dphs_pkg::OP_POP_BACK: begin
                if (held_words.size() == 0) begin
                    rep.status = dphs_pkg::ST_EMPTY;
                end else if (op == dphs_pkg::OP_POP_FRONT) begin
                    void'(held_words.pop_front());
                end else begin
                    void'(held_words.pop_back());
                end
            end
            default: begin
            end
        endcase
        n = held_words.size();
        rep.count = CNT_W'(n);
        rep.palindrome = 1'b1;
        front_sum = 0;
        back_sum = 0;
        for (int i = 0; i < n / 2; i++) begin
            if (held_words[i] != held_words[n-1-i])
                rep.palindrome = 1'b0;
            front_sum += longint'($signed(held_words[i]));
            back_sum += longint'($signed(held_words[n-1-i]));
        end
        rep.halves = (front_sum == back_sum);
        return rep;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return WORD_NEG;
            3, 4: return WORD_W'($urandom_range(0, 3));
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            s_value <= $urandom();
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_value <= word;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_reports.push_back(deque_apply(op, word));
        sent_items++;
    endtask

    task automatic wait_all_reports();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    task automatic test_empty_queue();
        send_op(dphs_pkg::OP_REPORT, WORD_NEG);
        send_op(dphs_pkg::OP_POP_FRONT, '0);
        send_op(dphs_pkg::OP_POP_BACK, WORD_NEG);
    endtask

    // wrapped 32-bit half sums would match here, exact sums do not
    task automatic test_wide_half_sums();
        send_op(dphs_pkg::OP_PUSH_BACK, '0);
        send_op(dphs_pkg::OP_PUSH_BACK, 32'hFFFF_FFFE);
        send_op(dphs_pkg::OP_PUSH_FRONT, WORD_MAX);
        send_op(dphs_pkg::OP_PUSH_FRONT, WORD_MAX);
    endtask

    task automatic test_fill_and_overflow();
        for (int i = 0; i < DEPTH - 4; i++) begin
            send_op(i % 2 ? dphs_pkg::OP_PUSH_BACK : dphs_pkg::OP_PUSH_FRONT,
                    i % 3 == 0 ? WORD_MIN : (i % 3 == 1 ? WORD_NEG : 32'h5555_AAAA));
        end
        send_op(dphs_pkg::OP_PUSH_FRONT, WORD_MAX);
        send_op(dphs_pkg::OP_PUSH_BACK, WORD_MIN);
    endtask

    task automatic test_pops_and_spare_ops();
        send_op(dphs_pkg::OP_POP_FRONT, WORD_MAX);
        send_op(dphs_pkg::OP_POP_BACK, '0);
        send_op(OP_SPARE_FIRST, WORD_NEG);
        send_op(OP_SPARE_LAST, '0);
    endtask

    task automatic test_drain_pause();
        wait_all_reports();
        send_op(dphs_pkg::OP_REPORT, '0);
    endtask

    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned next_pause;
        int unsigned burst;
        logic [WORD_W-1:0] word;
        stop_at = sent_items + RANDOM_ITEMS;
        next_pause = sent_items + PAUSE_EVERY;
        while (sent_items < stop_at) begin
            calm = (sent_items + 1000 > stop_at) && (sent_items + 700 <= stop_at);
            if (sent_items >= next_pause) begin
                wait_all_reports();
                next_pause += PAUSE_EVERY;
            end
            burst = $urandom_range(4, 20);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    // mirrored growth keeps palindromes alive
                    repeat (burst) begin
                        if ($urandom_range(0, 3) != 0) begin
                            word = pick_word();
                            send_op(dphs_pkg::OP_PUSH_FRONT, word);
                            send_op(dphs_pkg::OP_PUSH_BACK, word);
                        end else begin
                            send_op(dphs_pkg::OP_POP_FRONT, $urandom());
                            send_op(dphs_pkg::OP_POP_BACK, $urandom());
                        end
                    end
                end
                4, 5: begin
                    while (held_words.size() < DEPTH) begin
                        send_op($urandom_range(0, 1) ? dphs_pkg::OP_PUSH_FRONT
                                                     : dphs_pkg::OP_PUSH_BACK,
                                pick_word());
                    end
                    repeat ($urandom_range(1, 3)) begin
                        send_op($urandom_range(0, 1) ? dphs_pkg::OP_PUSH_FRONT
                                                     : dphs_pkg::OP_PUSH_BACK,
                                pick_word());
                    end
                end
                6, 7: begin
                    while (held_words.size() > 0) begin
                        send_op($urandom_range(0, 1) ? dphs_pkg::OP_POP_FRONT
                                                     : dphs_pkg::OP_POP_BACK,
                                $urandom());
                    end
                    repeat ($urandom_range(1, 3)) begin
                        send_op($urandom_range(0, 1) ? dphs_pkg::OP_POP_FRONT
                                                     : dphs_pkg::OP_POP_BACK,
                                $urandom());
                    end
                end
                default: begin
                    repeat (burst) begin
                        send_op(OP_W'($urandom_range(0, 7)), pick_word());
                    end
                end
            endcase
        end
        calm = 1'b0;
    endtask

    initial begin
        aresetn <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_queue();
        test_wide_half_sums();
        test_fill_and_overflow();
        test_pops_and_spare_ops();
        test_drain_pause();
        test_random_traffic();
        wait_all_reports();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("deque_palindrome_halfsum_unit test passed");
        end else begin
            $display("deque_palindrome_halfsum_unit test failed");
        end
        $finish;
    end

    // result checker and receiver stall generator
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("unexpected result transfer, count %0d", m_entry_count);
                mismatch_count++;
            end else begin
                oldest_report = pending_reports.pop_front();
                if (m_entry_count !== oldest_report.count) begin
                    $error("m_entry_count: expected %0d, got %0d",
                           oldest_report.count, m_entry_count);
                    mismatch_count++;
                end
                if (m_is_palindrome !== oldest_report.palindrome) begin
                    $error("m_is_palindrome: expected %0b, got %0b",
                           oldest_report.palindrome, m_is_palindrome);
                    mismatch_count++;
                end
                if (m_halves_equal !== oldest_report.halves) begin
                    $error("m_halves_equal: expected %0b, got %0b",
                           oldest_report.halves, m_halves_equal);
                    mismatch_count++;
                end
                if (m_status !== oldest_report.status) begin
                    $error("m_status: expected %0d, got %0d",
                           oldest_report.status, m_status);
                    mismatch_count++;
                end
            end
        end
        m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("deque_palindrome_halfsum_unit test failed");
        $finish;
    end

endmodule
